// ----- hdl/font_glyph_tile_unpacker_core_defines.svh -----
// Assertion macros shared by the unpacker modules.
// They expect signals named clk and rst_n in the module that uses them.
`ifndef FONT_GLYPH_TILE_UNPACKER_CORE_DEFINES_SVH
`define FONT_GLYPH_TILE_UNPACKER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define FGTU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define FGTU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FGTU_ASSERT_IMP(lbl, ante, cons, msg)
`define FGTU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/fgtu_pkg.sv -----
package fgtu_pkg;

    // Parser phase, also reported on every result
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SEARCH = 3'd1,
        PH_GHDR   = 3'd2,
        PH_TILES  = 3'd3,
        PH_DONE   = 3'd4,
        PH_ERROR  = 3'd5
    } phase_t;

    // Bits per pixel
    typedef enum logic [1:0] {
        DEPTH_1 = 2'd0,
        DEPTH_2 = 2'd1,
        DEPTH_4 = 2'd2
    } depth_t;

    localparam logic [31:0] GLYPH_TAG   = 32'h43474C50;
    // Last byte index of the file header (16 bytes)
    localparam logic [3:0]  HEADER_LAST = 4'd15;
    // Size of the tag and size words that open each block
    localparam logic [31:0] BLOCK_OPEN  = 32'd8;

    // One classified byte: what the back end has to emit for it
    typedef struct packed {
        logic [7:0] data;
        depth_t     depth;
        logic [3:0] count;   // pixels to emit, 0 means one empty result
        logic       eog;     // last pixel of this byte closes the glyph
        phase_t     phase;
    } pix_cmd_t;

endpackage

// ----- hdl/fgtu_in_if.sv -----
interface fgtu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

// ----- hdl/fgtu_out_if.sv -----
interface fgtu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       pixel_valid;
    logic       end_of_glyph;
    logic       last;
    logic [2:0] phase;

    modport source (output valid, output pixel, output pixel_valid, output end_of_glyph,
                    output last, output phase, input ready);
    modport sink   (input valid, input pixel, input pixel_valid, input end_of_glyph,
                    input last, input phase, output ready);
endinterface

// ----- hdl/fgtu_front.sv -----
module fgtu_front
    import fgtu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fgtu_in_if.sink    file_stream,
    output logic       push_valid,
    output pix_cmd_t   push_data,
    input  logic       push_ready
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] word_reg, word_next;
    logic        tag_reg, tag_next;
    logic [7:0]  width_reg, width_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] tile_reg, tile_next;
    depth_t      depth_reg, depth_next;
    logic [15:0] tile_cnt_reg, tile_cnt_next;
    logic [15:0] gpc_reg, gpc_next;

    phase_t      phase_c;
    logic [3:0]  pos_c;
    logic [31:0] remain_c;
    logic [31:0] word_c;
    logic        tag_c;
    logic [7:0]  b;
    logic        accept;

    logic [31:0] word_or;
    logic [31:0] remain_dec;
    logic [15:0] tile_c;
    logic [18:0] eight_t;
    logic [18:0] t1, t2, t3, t4, t5;
    logic [3:0]  per;
    logic [15:0] avail;
    logic [3:0]  n_pix;
    logic        eog;
    logic [16:0] tile_inc;

    assign b          = file_stream.data_byte;
    assign accept     = file_stream.valid && push_ready;
    assign file_stream.ready = push_ready;
    assign push_valid = file_stream.valid;

    // State registers, advanced once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            remain_reg   <= '0;
            word_reg     <= '0;
            tag_reg      <= 1'b0;
            width_reg    <= '0;
            total_reg    <= '0;
            tile_reg     <= '0;
            depth_reg    <= DEPTH_1;
            tile_cnt_reg <= '0;
            gpc_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            remain_reg   <= remain_next;
            word_reg     <= word_next;
            tag_reg      <= tag_next;
            width_reg    <= width_next;
            total_reg    <= total_next;
            tile_reg     <= tile_next;
            depth_reg    <= depth_next;
            tile_cnt_reg <= tile_cnt_next;
            gpc_reg      <= gpc_next;
        end
    end

    // Start of file restarts the parser on this very byte
    always_comb
    begin
        phase_c  = file_stream.start_of_file ? PH_HEADER : phase_reg;
        pos_c    = file_stream.start_of_file ? 4'd0 : pos_reg;
        remain_c = file_stream.start_of_file ? 32'd0 : remain_reg;
        word_c   = file_stream.start_of_file ? 32'd0 : word_reg;
        tag_c    = file_stream.start_of_file ? 1'b0 : tag_reg;
    end

    // Shared helpers for the phase logic
    always_comb
    begin
        word_or    = word_c | ({24'd0, b} << {pos_c[1:0], 3'b000});
        remain_dec = (remain_c != 32'd0) ? remain_c - 32'd1 : remain_c;
        tile_c     = {b, word_c[7:0]};
        eight_t    = {tile_c, 3'b000};
        t1         = {3'b000, total_reg};
        t2         = {2'b00, total_reg, 1'b0};
        t3         = t1 + t2;
        t4         = {1'b0, total_reg, 2'b00};
        t5         = t1 + t4;
        unique case (depth_reg)
            DEPTH_1: per = 4'd8;
            DEPTH_2: per = 4'd4;
            DEPTH_4: per = 4'd2;
            default: per = 4'd8;
        endcase
        avail = total_reg - gpc_reg;
        if (avail == 16'd0)
            n_pix = 4'd0;
        else if (avail < {12'd0, per})
            n_pix = avail[3:0];
        else
            n_pix = per;
        eog      = (avail != 16'd0) && (avail <= {12'd0, per});
        tile_inc = {1'b0, tile_cnt_reg} + 17'd1;
    end

    // Phase machine: next state and the command for the back end
    always_comb
    begin
        phase_next    = phase_c;
        pos_next      = pos_c;
        remain_next   = remain_c;
        word_next     = word_c;
        tag_next      = tag_c;
        width_next    = width_reg;
        total_next    = total_reg;
        tile_next     = tile_reg;
        depth_next    = depth_reg;
        tile_cnt_next = tile_cnt_reg;
        gpc_next      = gpc_reg;
        push_data.count = 4'd0;
        push_data.eog   = 1'b0;

        unique case (phase_c)
            PH_HEADER:
            begin
                if (pos_c == HEADER_LAST)
                begin
                    pos_next   = '0;
                    word_next  = '0;
                    phase_next = PH_SEARCH;
                end
                else
                    pos_next = pos_c + 4'd1;
            end
            PH_SEARCH:
            begin
                if (remain_c != 32'd0)
                    remain_next = remain_c - 32'd1;
                else
                begin
                    word_next = word_or;
                    pos_next  = pos_c + 4'd1;
                    if (pos_c == 4'd3)
                    begin
                        tag_next  = (word_or == GLYPH_TAG);
                        word_next = '0;
                    end
                    if (pos_c == 4'd7)
                    begin
                        word_next = '0;
                        pos_next  = '0;
                        tag_next  = 1'b0;
                        if (word_or < BLOCK_OPEN)
                            phase_next = PH_ERROR;
                        else
                        begin
                            remain_next = word_or - BLOCK_OPEN;
                            if (tag_c)
                                phase_next = PH_GHDR;
                        end
                    end
                end
            end
            PH_GHDR:
            begin
                remain_next = remain_dec;
                pos_next    = pos_c + 4'd1;
                unique case (pos_c)
                    4'd0: width_next = b;
                    4'd1: total_next = 16'(width_reg) * 16'(b);
                    4'd2: word_next  = {24'd0, b};
                    4'd3:
                    begin
                        tile_next = tile_c;
                        word_next = '0;
                        // depth = 8*tile / (width*height), must be 1, 2 or 4
                        if (total_reg != 16'd0 && eight_t >= t1 && eight_t < t2)
                            depth_next = DEPTH_1;
                        else if (total_reg != 16'd0 && eight_t >= t2 && eight_t < t3)
                            depth_next = DEPTH_2;
                        else if (total_reg != 16'd0 && eight_t >= t4 && eight_t < t5)
                            depth_next = DEPTH_4;
                        else
                        begin
                            phase_next = PH_ERROR;
                            pos_next   = pos_c;
                        end
                    end
                    4'd7:
                    begin
                        pos_next      = '0;
                        tile_cnt_next = '0;
                        gpc_next      = '0;
                        phase_next    = (remain_dec >= {16'd0, tile_reg}) ? PH_TILES : PH_DONE;
                    end
                    default: ;
                endcase
            end
            PH_TILES:
            begin
                push_data.count = n_pix;
                push_data.eog   = eog;
                gpc_next        = gpc_reg + {12'd0, n_pix};
                remain_next     = remain_dec;
                tile_cnt_next   = tile_inc[15:0];
                if (tile_inc >= {1'b0, tile_reg})
                begin
                    tile_cnt_next = '0;
                    gpc_next      = '0;
                    phase_next    = (remain_dec >= {16'd0, tile_reg}) ? PH_TILES : PH_DONE;
                end
            end
            default: ;
        endcase

        push_data.data  = b;
        push_data.depth = depth_reg;
        push_data.phase = phase_next;
    end

endmodule

// ----- hdl/fgtu_queue.sv -----
module fgtu_queue
    import fgtu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    input  pix_cmd_t push_data,
    output logic     push_ready,
    output logic     pop_valid,
    output pix_cmd_t pop_data,
    input  logic     pop_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pix_cmd_t        entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (!do_push && do_pop)
                count_reg <= count_reg - CW'(1);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hdl/fgtu_back.sv -----
`include "font_glyph_tile_unpacker_core_defines.svh"

module fgtu_back
    import fgtu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    input  pix_cmd_t  pop_data,
    output logic      pop_ready,
    fgtu_out_if.source pixel_stream
);

    logic       busy_reg;
    pix_cmd_t   cmd_reg;
    logic [7:0] shift_reg;
    logic [3:0] rem_reg;

    logic       pix_valid_c;
    logic       last_c;
    logic       eog_c;
    logic       step;
    logic       load;
    logic [7:0] scaled;
    logic [7:0] shifted;

    assign pix_valid_c = (cmd_reg.count != 4'd0);
    assign last_c      = !pix_valid_c || (rem_reg == 4'd1);
    assign eog_c       = cmd_reg.eog && pix_valid_c && (rem_reg == 4'd1);
    assign step        = busy_reg && pixel_stream.ready;
    assign pop_ready   = !busy_reg || (step && last_c);
    assign load        = pop_ready && pop_valid;

    // Top bits scaled to 0..255: replication equals *255, *85, *17
    always_comb
    begin
        unique case (cmd_reg.depth)
            DEPTH_1:
            begin
                scaled  = {8{shift_reg[7]}};
                shifted = {shift_reg[6:0], 1'b0};
            end
            DEPTH_2:
            begin
                scaled  = {4{shift_reg[7:6]}};
                shifted = {shift_reg[5:0], 2'b00};
            end
            DEPTH_4:
            begin
                scaled  = {2{shift_reg[7:4]}};
                shifted = {shift_reg[3:0], 4'b0000};
            end
            default:
            begin
                scaled  = {8{shift_reg[7]}};
                shifted = {shift_reg[6:0], 1'b0};
            end
        endcase
    end

    // Result beat, straight from registers
    assign pixel_stream.valid        = busy_reg;
    assign pixel_stream.pixel        = pix_valid_c ? scaled : 8'd0;
    assign pixel_stream.pixel_valid  = pix_valid_c;
    assign pixel_stream.end_of_glyph = eog_c;
    assign pixel_stream.last         = last_c;
    assign pixel_stream.phase        = cmd_reg.phase;

    // Busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (load)
            busy_reg <= 1'b1;
        else if (step && last_c)
            busy_reg <= 1'b0;
    end

    // Working command: load a new one or walk to the next pixel
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg   <= pop_data;
            shift_reg <= pop_data.data;
            rem_reg   <= pop_data.count;
        end
        else if (step && !last_c)
        begin
            shift_reg <= shifted;
            rem_reg   <= rem_reg - 4'd1;
        end
    end

    `FGTU_ASSERT_IMP(a_empty_is_last, busy_reg && cmd_reg.count == 4'd0, last_c, "empty beat not last")
    `FGTU_ASSERT_IMP(a_eog_on_last, busy_reg && eog_c, last_c && pix_valid_c, "glyph end not on last pixel")
    `FGTU_ASSERT_IMP(a_rem_live, busy_reg && pix_valid_c, rem_reg != 4'd0, "pixel beat with no pixels left")
    `FGTU_ASSERT_NEXT(a_walk, step && !last_c, busy_reg && rem_reg == $past(rem_reg) - 4'd1, "pixel walk broken")

endmodule

// ----- hdl/font_glyph_tile_unpacker_core.sv -----
// Glyph tile unpacker core.
// file_stream takes the font file one byte per beat (data_byte, with
// start_of_file on byte 0 of each file). pixel_stream gives the results:
// one beat per decoded pixel, or one empty beat (pixel_valid 0) for a byte
// that yields no pixel; last marks the final beat of each byte and phase
// gives the parser phase after that byte.
// The front end parses one byte per cycle while the queue has room and hands
// a command to a short queue; the back end sends one result beat per cycle
// from that command while the receiver is ready. A byte's command is written
// into the queue, then loaded into the back end's command register, from
// which its first beat is driven. A byte holds up to 8 pixels at 1 bit per
// pixel, 4 at 2 bits and 2 at 4 bits; header and skipped bytes give one empty
// beat each; the back end walks a byte's pixels one per cycle when not stalled.
// Bytes keep being taken while the queue has room.
// Reset: parser back to header skip, queue and back end empty; no clearing pass.
// When the receiver stalls, the current beat holds and the queue fills; then
// file_stream ready drops until a slot frees.
module font_glyph_tile_unpacker_core
    import fgtu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    fgtu_in_if.sink     file_stream,
    fgtu_out_if.source  pixel_stream
);

    logic     push_valid, push_ready;
    pix_cmd_t push_data;
    logic     pop_valid, pop_ready;
    pix_cmd_t pop_data;

    // Parser and classifier
    fgtu_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .file_stream (file_stream),
        .push_valid  (push_valid),
        .push_data   (push_data),
        .push_ready  (push_ready)
    );

    // Command queue between the two sides
    fgtu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    // Pixel emitter
    fgtu_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_data     (pop_data),
        .pop_ready    (pop_ready),
        .pixel_stream (pixel_stream)
    );

endmodule

// ----- sim/fgtu_pixel_checker.sv -----
// Pixel stream checker: watches both channels, decodes each accepted file byte
// into the pixel beats it should cause, and compares them in order with the
// beats that leave the block.
module fgtu_pixel_checker
    import fgtu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fgtu_in_if   in_mon,
    fgtu_out_if  out_mon,
    output int   mismatches,
    output int   backlog
);

    typedef struct packed {
        logic [7:0] pixel;
        logic       pix_valid;
        logic       eog;
        logic       last;
        phase_t     phase;
    } pixel_beat_t;

    pixel_beat_t pixel_beats_q[$];

    // Parser copy
    phase_t      ph;
    logic [31:0] pos;
    logic [31:0] remain;
    logic [31:0] acc;
    logic [7:0]  cw;
    logic [7:0]  ch;
    logic [15:0] tsize;
    logic [2:0]  bpp;
    logic [15:0] tcount;
    logic [15:0] gcount;
    logic        tag_hit;

    task automatic clear_parser();
        ph      = PH_HEADER;
        pos     = '0;
        remain  = '0;
        acc     = '0;
        cw      = '0;
        ch      = '0;
        tsize   = '0;
        bpp     = '0;
        tcount  = '0;
        gcount  = '0;
        tag_hit = 1'b0;
    endtask

    // Decode one file byte and queue the pixel beats it yields
    task automatic unpack_byte(input logic [7:0] b, input logic sof);
        logic [7:0]  vals [8];
        logic        eogs [8];
        int unsigned n;
        int unsigned total;
        int unsigned per;
        int unsigned mask;
        int unsigned scale;
        int unsigned sh;
        int unsigned d;
        logic        stop;
        pixel_beat_t beat;

        n    = 0;
        stop = 1'b0;
        if (sof)
            clear_parser();

        case (ph)
            PH_HEADER:
            begin
                pos++;
                if (pos >= 32'(HEADER_LAST) + 1)
                begin
                    pos = '0;
                    acc = '0;
                    ph  = PH_SEARCH;
                end
            end
            PH_SEARCH:
            begin
                if (remain > 0)
                    remain--;
                else
                begin
                    // tag word, then size word, both little-endian
                    acc |= 32'(b) << (8 * pos[1:0]);
                    if (pos == 3)
                    begin
                        tag_hit = (acc == GLYPH_TAG);
                        acc     = '0;
                    end
                    pos++;
                    if (pos >= 8)
                    begin
                        if (acc < BLOCK_OPEN)
                            ph = PH_ERROR;
                        else
                        begin
                            remain = acc - BLOCK_OPEN;
                            if (tag_hit)
                                ph = PH_GHDR;
                        end
                        acc     = '0;
                        pos     = '0;
                        tag_hit = 1'b0;
                    end
                end
            end
            PH_GHDR:
            begin
                if (remain > 0)
                    remain--;
                case (pos)
                    0: cw = b;
                    1: ch = b;
                    2: acc = 32'(b);
                    3:
                    begin
                        tsize = {b, acc[7:0]};
                        acc   = '0;
                        d     = 0;
                        if (cw != 0 && ch != 0)
                            d = (8 * int'(tsize)) / int'(cw) / int'(ch);
                        if (d == 1 || d == 2 || d == 4)
                            bpp = 3'(d);
                        else
                        begin
                            bpp  = '0;
                            ph   = PH_ERROR;
                            stop = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (!stop)
                begin
                    pos++;
                    if (pos >= 8)
                    begin
                        pos    = '0;
                        tcount = '0;
                        gcount = '0;
                        ph     = (remain >= 32'(tsize)) ? PH_TILES : PH_DONE;
                    end
                end
            end
            PH_TILES:
            begin
                total = int'(cw) * int'(ch);
                per   = 8 / bpp;
                mask  = (1 << bpp) - 1;
                scale = (bpp == 1) ? 255 : ((bpp == 2) ? 85 : 17);
                // MSB first; bits past the cell's pixel count are dropped
                for (int unsigned k = 0; k < per; k++)
                begin
                    if (gcount < total)
                    begin
                        sh      = 8 - bpp * (k + 1);
                        vals[n] = 8'(((b >> sh) & mask) * scale);
                        gcount++;
                        eogs[n] = (gcount == total);
                        n++;
                    end
                end
                if (remain > 0)
                    remain--;
                tcount++;
                if (tcount >= tsize)
                begin
                    tcount = '0;
                    gcount = '0;
                    ph     = (remain >= 32'(tsize)) ? PH_TILES : PH_DONE;
                end
            end
            default: ;
        endcase

        if (n == 0)
        begin
            beat = '{pixel: 8'h00, pix_valid: 1'b0, eog: 1'b0, last: 1'b1, phase: ph};
            pixel_beats_q = {pixel_beats_q, beat};
        end
        else
        begin
            for (int unsigned k = 0; k < n; k++)
            begin
                beat = '{pixel: vals[k], pix_valid: 1'b1, eog: eogs[k],
                         last: (k + 1 == n), phase: ph};
                pixel_beats_q = {pixel_beats_q, beat};
            end
        end
    endtask

    task automatic report(input string msg);
        if (mismatches < 10)
            $display("%s", msg);
        mismatches++;
    endtask

    // Predict on accepted file beats, compare on accepted pixel beats
    always @(posedge clk or negedge rst_n)
    begin
        pixel_beat_t got;
        pixel_beat_t want;

        if (!rst_n)
        begin
            clear_parser();
            pixel_beats_q.delete();
            mismatches <= 0;
            backlog    <= 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
                unpack_byte(in_mon.data_byte, in_mon.start_of_file);

            if (out_mon.valid && out_mon.ready)
            begin
                got = '{pixel: out_mon.pixel, pix_valid: out_mon.pixel_valid,
                        eog: out_mon.end_of_glyph, last: out_mon.last,
                        phase: phase_t'(out_mon.phase)};
                if (pixel_beats_q.size() == 0)
                    report($sformatf("unexpected pixel beat: pix=%02h pv=%0b eog=%0b last=%0b ph=%0d",
                                     got.pixel, got.pix_valid, got.eog, got.last, got.phase));
                else
                begin
                    want = pixel_beats_q.pop_front();
                    if (got.pixel !== want.pixel || got.pix_valid !== want.pix_valid ||
                        got.eog !== want.eog || got.last !== want.last ||
                        got.phase !== want.phase)
                        report($sformatf({"pixel beat mismatch: got pix=%02h pv=%0b eog=%0b ",
                                          "last=%0b ph=%0d, want pix=%02h pv=%0b eog=%0b ",
                                          "last=%0b ph=%0d"},
                                         got.pixel, got.pix_valid, got.eog, got.last,
                                         got.phase, want.pixel, want.pix_valid, want.eog,
                                         want.last, want.phase));
                end
            end
            backlog <= pixel_beats_q.size();
        end
    end

endmodule

// ----- sim/font_glyph_tile_unpacker_core_tb.sv -----
module font_glyph_tile_unpacker_core_tb
    import fgtu_pkg::*;
();

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   backlog;
    int   bytes_sent = 0;

    fgtu_in_if  file_if ();
    fgtu_out_if pix_if ();

    font_glyph_tile_unpacker_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .file_stream  (file_if),
        .pixel_stream (pix_if)
    );

    fgtu_pixel_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (file_if),
        .out_mon    (pix_if),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle stretch: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // One file beat, waits for acceptance
    task automatic send_beat(input logic [7:0] b, input logic sof);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            file_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        file_if.valid         <= 1'b1;
        file_if.data_byte     <= b;
        file_if.start_of_file <= sof;
        @(posedge clk);
        while (!file_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Whole font file: header, skip blocks, glyph block, trailing bytes.
    // spare adds payload after the full tiles (negative cuts into the glyph
    // header); skip_mode 1 puts a block size below 8, 2 a huge block size;
    // cut > 0 truncates the file at that byte.
    task automatic send_font(input logic [7:0] w, input logic [7:0] h, input logic [15:0] tile,
                             input int n_tiles, input int spare, input int n_skip,
                             input int skip_mode, input int cut);
        logic [7:0]  img[$];
        logic [31:0] word;
        int          payload;
        int          r;

        repeat (16) img = {img, 8'($urandom)};

        // skipped blocks
        for (int i = 0; i < n_skip + (skip_mode != 0); i++)
        begin
            word = $urandom;
            if (word == GLYPH_TAG)
                word[0] = ~word[0];
            for (int k = 0; k < 4; k++)
                img = {img, word[8*k +: 8]};
            payload = $urandom_range(0, 6);
            if (i == 0 && skip_mode == 1)
                word = $urandom_range(0, 7);
            else if (i == 0 && skip_mode == 2)
                word = 32'hFFFF_FFFF;
            else
                word = BLOCK_OPEN + payload;
            for (int k = 0; k < 4; k++)
                img = {img, word[8*k +: 8]};
            repeat (payload) img = {img, 8'($urandom)};
        end

        // glyph block
        payload = n_tiles * int'(tile) + spare;
        word    = (payload < -8) ? BLOCK_OPEN : 32'(16 + payload);
        for (int k = 0; k < 4; k++)
            img = {img, GLYPH_TAG[8*k +: 8]};
        for (int k = 0; k < 4; k++)
            img = {img, word[8*k +: 8]};
        img = {img, w};
        img = {img, h};
        img = {img, tile[7:0]};
        img = {img, tile[15:8]};
        repeat (4) img = {img, 8'($urandom)};
        for (int i = 0; i < payload; i++)
        begin
            r = $urandom_range(0, 9);
            img = {img, ((r == 0) ? 8'h00 : ((r == 1) ? 8'hFF : 8'($urandom)))};
        end
        repeat ($urandom_range(0, 3)) img = {img, 8'($urandom)};

        if (cut > 0 && cut < img.size())
            img = img[0:cut-1];
        foreach (img[i])
            send_beat(img[i], i == 0);
    endtask

    // Random font, sometimes truncated: tile size picked so the derived depth is valid
    task automatic send_random_font();
        int w;
        int h;
        int d;
        int lo;
        int hi;
        int n_tiles;
        int spare;
        int cut;
        int r;

        r = $urandom_range(0, 2);
        d = (r == 0) ? 1 : ((r == 1) ? 2 : 4);
        do
        begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            lo = (d * h * w + 7) / 8;
            hi = ((d + 1) * h * w + 7) / 8 - 1;
        end
        while (lo > hi);
        n_tiles = $urandom_range(1, 4);
        // occasional full-width or full-height cell
        if ($urandom_range(0, 24) == 0)
        begin
            d       = 1;
            w       = ($urandom_range(0, 1) == 0) ? 255 : 1;
            h       = (w == 255) ? 1 : 255;
            lo      = 32;
            hi      = 63;
            n_tiles = 1;
        end
        lo    = $urandom_range(lo, hi);
        spare = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(0, lo - 1);
        cut   = ($urandom_range(0, 99) < 15) ? $urandom_range(17, 40 + n_tiles * lo) : 0;
        send_font(8'(w), 8'(h), 16'(lo), n_tiles, spare, $urandom_range(0, 2), 0, cut);
    endtask

    // Receiver: ready runs and stalls of random length
    initial
    begin
        int gap;
        pix_if.ready <= 1'b0;
        forever
        begin
            gap = idle_len();
            if (gap > 0)
            begin
                @(posedge clk);
                pix_if.ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            @(posedge clk);
            pix_if.ready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(posedge clk);
        end
    end

    initial
    begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int r;
        int nz;

        file_if.valid         <= 1'b0;
        file_if.data_byte     <= 8'h00;
        file_if.start_of_file <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed files
        send_font(8'd8, 8'd1, 16'd1, 2, 0, 0, 0, 0);        // 1 bit per pixel
        send_font(8'd2, 8'd2, 16'd1, 2, 0, 1, 0, 0);        // 2 bits, after a skip block
        send_font(8'd1, 8'd2, 16'd1, 2, 0, 0, 0, 0);        // 4 bits
        send_font(8'd3, 8'd3, 16'd2, 2, 1, 0, 0, 0);        // spare bits, partial tile
        send_font(8'd4, 8'd0, 16'd4, 1, 0, 0, 0, 0);        // zero height
        send_font(8'd1, 8'd1, 16'hFFFF, 0, 0, 0, 0, 0);     // depth far too large
        send_font(8'd2, 8'd2, 16'd1, 1, 0, 0, 1, 0);        // block size below 8

        // random part, up to the overall byte budget
        while (bytes_sent < 350)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                send_random_font();
            else if (r < 88)
            begin
                // broken file
                case ($urandom_range(0, 4))
                    0: send_font(8'($urandom_range(1, 8)), 8'd2, 16'd1, 1, 0, 1, 1, 0);
                    1: send_font(8'd0, 8'($urandom), 16'($urandom), 1, 0, 0, 0, 0);
                    2: send_font(8'($urandom), 8'($urandom), 16'($urandom_range(0, 3)),
                                 1, 0, 0, 0, 0);
                    3: send_font(8'd2, 8'd2, 16'd1, 0, -$urandom_range(1, 8), 0, 0, 0);
                    default: send_font(8'd2, 8'd2, 16'd1, 1, 0, 0, 2, 0);
                endcase
            end
            else
            begin
                // loose bytes, restarting now and then
                nz = $urandom_range(5, 20);
                for (int i = 0; i < nz; i++)
                    send_beat(8'($urandom), $urandom_range(0, 5) == 0);
            end
        end

        // drop valid on the edge that took the last byte
        file_if.valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0 && backlog == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
